// File: hdl/assert_macros.svh
// Assertion macros used by the checker module of the list core.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/ilid_pkg.sv
// Package of the indexed list core: sizes, operation and status codes,
// and the control word broadcast to the cell row. Depends on nothing.
package ilid_pkg;

    localparam int CAPACITY   = 64;
    localparam int ELEM_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [OP_W-1:0] OP_ADD_FRONT    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_REAR     = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_REAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT_AT    = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef logic [ELEM_WIDTH-1:0] elem_t;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] pos;
        elem_t            val;
    } cell_ctrl_t;

endpackage

// File: hdl/ilid_req_if.sv
// Request channel of the list core: valid, ready and one operation word.
// Depends on ilid_pkg for the field widths.
interface ilid_req_if;
    logic                               valid;
    logic                               ready;
    logic        [ilid_pkg::OP_W-1:0]    op;
    logic        [ilid_pkg::POS_W-1:0]   position;
    logic signed [ilid_pkg::VALUE_W-1:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

// File: hdl/ilid_rsp_if.sv
// Response channel of the list core: valid, ready and one result word.
// Depends on ilid_pkg for the field widths.
interface ilid_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [ilid_pkg::VALUE_W-1:0]  removed_value;
    logic        [ilid_pkg::STATUS_W-1:0] status;
    logic        [ilid_pkg::CNT_W-1:0]    count_now;
    logic                                is_empty;

    modport source (output valid, output removed_value, output status, output count_now,
                    output is_empty, input ready);
    modport sink   (input valid, input removed_value, input status, input count_now,
                    input is_empty, output ready);
endinterface

// File: hdl/indexed_list_insert_delete_core.sv
// Ordered list of up to CAPACITY elements with front, rear and positional
// insert and remove. Every request word yields one response word carrying the
// status, the element taken out by a removal, the new count and an empty flag.
// An operation completes in the cycle it is accepted: the whole cell row shifts
// toward the front or the rear in parallel, and the response is registered and
// shown in the cycle after. A new request is taken in every cycle in which the
// response register is empty or being emptied, so the sustained rate is one word
// per cycle. Cell contents need no clearing; only positions below the count are read.
// Depends on ilid_pkg, ilid_req_if, ilid_rsp_if, ilid_ctrl and ilid_cell.
module indexed_list_insert_delete_core (
    input  logic       clk,
    input  logic       rst_n,
    ilid_req_if.sink   req,
    ilid_rsp_if.source rsp
);
    import ilid_pkg::*;

    logic                rsp_valid_reg;
    logic [VALUE_W-1:0]  removed_reg;
    logic [VALUE_W-1:0]  removed_next;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                accept;
    cell_ctrl_t          dec_ctrl;
    cell_ctrl_t          row_ctrl;
    logic [STATUS_W-1:0] dec_status;
    elem_t               cell_data [CAPACITY];
    elem_t               cell_sel  [CAPACITY];
    elem_t               picked;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    ilid_ctrl u_ctrl (
        .op         (req.op),
        .position   (req.position),
        .value      ($unsigned(req.value)),
        .count      (count_reg),
        .ctrl       (dec_ctrl),
        .status     (dec_status),
        .count_next (count_next)
    );

    always_comb
    begin
        row_ctrl     = dec_ctrl;
        row_ctrl.ins = dec_ctrl.ins && accept;
        row_ctrl.rem = dec_ctrl.rem && accept;
    end

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        ilid_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(k)),
            .ctrl       (row_ctrl),
            .left_data  ((k == 0) ? elem_t'(0) : cell_data[(k == 0) ? 0 : k - 1]),
            .right_data ((k == CAPACITY - 1) ? elem_t'(0)
                                             : cell_data[(k == CAPACITY - 1) ? k : k + 1]),
            .data       (cell_data[k]),
            .sel_data   (cell_sel[k])
        );
    end

    always_comb
    begin
        picked = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            picked = picked | cell_sel[k];
        end
        removed_next = dec_ctrl.rem ? VALUE_W'(picked) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg <= removed_next;
            status_reg  <= dec_status;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.removed_value = $signed(removed_reg);
    assign rsp.status        = status_reg;
    assign rsp.count_now     = count_reg;
    assign rsp.is_empty      = (count_reg == '0);
endmodule

// File: hdl/ilid_cell.sv
// One storage cell of the list row: holds one element and shifts toward
// either neighbor on an insert or a removal. Depends on ilid_pkg.
module ilid_cell (
    input  logic                      clk,
    input  logic [ilid_pkg::IDX_W-1:0] idx,
    input  ilid_pkg::cell_ctrl_t      ctrl,
    input  ilid_pkg::elem_t           left_data,
    input  ilid_pkg::elem_t           right_data,
    output ilid_pkg::elem_t           data,
    output ilid_pkg::elem_t           sel_data
);
    import ilid_pkg::*;

    elem_t data_reg;
    elem_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (idx > ctrl.pos)
            begin
                data_next = left_data;
            end
            else if (idx == ctrl.pos)
            begin
                data_next = ctrl.val;
            end
        end
        else if (ctrl.rem)
        begin
            if (idx >= ctrl.pos)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = (idx == ctrl.pos) ? data_reg : '0;
endmodule

// File: hdl/ilid_ctrl.sv
// Operation decoder of the list core: checks the request against the count
// and gives the status, the next count and the cell row control. Depends on ilid_pkg.
module ilid_ctrl (
    input  logic [ilid_pkg::OP_W-1:0]     op,
    input  logic [ilid_pkg::POS_W-1:0]    position,
    input  logic [ilid_pkg::VALUE_W-1:0]  value,
    input  logic [ilid_pkg::CNT_W-1:0]    count,
    output ilid_pkg::cell_ctrl_t          ctrl,
    output logic [ilid_pkg::STATUS_W-1:0] status,
    output logic [ilid_pkg::CNT_W-1:0]    count_next
);
    import ilid_pkg::*;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;
    logic             empty;

    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count);
    assign full    = (count == CNT_W'(CAPACITY));
    assign empty   = (count == '0);

    always_comb
    begin
        ctrl.ins = 1'b0;
        ctrl.rem = 1'b0;
        ctrl.pos = '0;
        ctrl.val = ELEM_WIDTH'(value);
        status   = ST_OK;
        unique case (op)
            OP_ADD_FRONT:
            begin
                if (full)
                    status = ST_FULL;
                else
                    ctrl.ins = 1'b1;
            end
            OP_ADD_REAR:
            begin
                ctrl.pos = IDX_W'(count);
                if (full)
                    status = ST_FULL;
                else
                    ctrl.ins = 1'b1;
            end
            OP_INSERT_AT:
            begin
                ctrl.pos = IDX_W'(pos_ext - CMP_W'(1));
                if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))
                    status = ST_RANGE;
                else if (full)
                    status = ST_FULL;
                else
                    ctrl.ins = 1'b1;
            end
            OP_REMOVE_FRONT:
            begin
                if (empty)
                    status = ST_UNDER;
                else
                    ctrl.rem = 1'b1;
            end
            OP_REMOVE_REAR:
            begin
                ctrl.pos = IDX_W'(count - CNT_W'(1));
                if (empty)
                    status = ST_UNDER;
                else
                    ctrl.rem = 1'b1;
            end
            OP_REMOVE_AT:
            begin
                ctrl.pos = IDX_W'(pos_ext - CMP_W'(1));
                if (pos_ext == '0 || pos_ext > cnt_ext)
                    status = ST_RANGE;
                else
                    ctrl.rem = 1'b1;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctrl.ins)
            count_next = count + CNT_W'(1);
        else if (ctrl.rem)
            count_next = count - CNT_W'(1);
        else
            count_next = count;
    end
endmodule

// File: hdl/ilid_checker.sv
// Port-level checker of the list core, attached to the top level by bind.
// Depends on ilid_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ilid_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [ilid_pkg::VALUE_W-1:0]  removed_value,
    input logic [ilid_pkg::STATUS_W-1:0] status,
    input logic [ilid_pkg::CNT_W-1:0]    count_now,
    input logic                          is_empty
);
    import ilid_pkg::*;

    `ASSERT_NEXT(a_rsp_holds, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(removed_value))
    `ASSERT_IMPLIES(a_empty_flag, clk, rst_n, rsp_valid, is_empty == (count_now == '0))
    `ASSERT_IMPLIES(a_under_empty, clk, rst_n, rsp_valid && status == ST_UNDER, count_now == '0 && removed_value == '0)
    `ASSERT_IMPLIES(a_full_count, clk, rst_n, rsp_valid && status == ST_FULL, count_now == CNT_W'(CAPACITY) && removed_value == '0)
endmodule

bind indexed_list_insert_delete_core ilid_checker u_ilid_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .removed_value (rsp.removed_value),
    .status        (rsp.status),
    .count_now     (rsp.count_now),
    .is_empty      (rsp.is_empty)
);
